[rtl/hsfp_pkg.sv]
`timescale 1ns / 1ps
// shared constants, codes and types for the five-point heat stencil
package hsfp_pkg;

    // fixed field widths
    localparam int VALUE_W    = 32;
    localparam int IDX_W      = 10;
    localparam int ALPHA_W    = 15;
    localparam int SIZE_W     = 11;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 2;

    // default grid limits
    localparam int MAX_COLS_DEF = 1024;
    localparam int MAX_ROWS_DEF = 1024;
    localparam int MIN_SIZE     = 3;

    localparam logic [SIZE_W-1:0] ROWS_RESET = 11'd1024;
    localparam logic [SIZE_W-1:0] COLS_RESET = 11'd1024;

    // arithmetic widths: laplacian sum, product, rounded product
    localparam int D_W        = 35;
    localparam int P_W        = 51;
    localparam int Q_W        = 35;
    localparam int SUM_W      = 36;
    localparam int ROUND_BIAS = 32768;
    localparam int FRAC_SHIFT = 16;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA = 2'd0,
        CFG_ROWS  = 2'd1,
        CFG_COLS  = 2'd2
    } cfg_idx_t;

    // per-word control carried alongside the data through the pipe
    typedef struct packed {
        logic             emit_up;    // word finishes the cell one row above
        logic             emit_own;   // word lies in the last row, copied out
        logic             interior;   // cell above is an interior cell
        logic             frame_end;  // own copy is the last cell of the grid
        logic [IDX_W-1:0] up_row;
        logic [IDX_W-1:0] own_row;
        logic [IDX_W-1:0] col;
    } tag_t;

endpackage

[rtl/hsfp_raster_ctrl.sv]
`timescale 1ns / 1ps
// raster position counters, grid size clamping and per-word control
module hsfp_raster_ctrl #(
    parameter int MAX_ROWS = hsfp_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = hsfp_pkg::MAX_COLS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              accept,
    input  logic [hsfp_pkg::SIZE_W-1:0]       rows_cfg,
    input  logic [hsfp_pkg::SIZE_W-1:0]       cols_cfg,
    output logic [$clog2(MAX_COLS)-1:0]       col,
    output logic [$clog2(MAX_COLS)-1:0]       col_plus,
    output hsfp_pkg::tag_t                    tag_reg
);

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int RLIM_W = ($clog2(MAX_ROWS + 1) > hsfp_pkg::SIZE_W) ?
                            $clog2(MAX_ROWS + 1) : hsfp_pkg::SIZE_W;
    localparam int CLIM_W = ($clog2(MAX_COLS + 1) > hsfp_pkg::SIZE_W) ?
                            $clog2(MAX_COLS + 1) : hsfp_pkg::SIZE_W;

    logic [ROW_W-1:0]  row_cnt_reg, row_cnt_next;
    logic [COL_W-1:0]  col_cnt_reg, col_cnt_next;
    logic [RLIM_W-1:0] rows_eff, row_last, row_ext;
    logic [CLIM_W-1:0] cols_eff, col_last, col_ext;
    logic              last_row, last_col;
    logic [31:0]       row32, row_up32, col32;
    hsfp_pkg::tag_t    tag_next;

    // sizes outside the legal range act as the nearest limit
    always_comb begin
        if (RLIM_W'(rows_cfg) < RLIM_W'(hsfp_pkg::MIN_SIZE)) begin
            rows_eff = RLIM_W'(hsfp_pkg::MIN_SIZE);
        end else if (RLIM_W'(rows_cfg) > RLIM_W'(MAX_ROWS)) begin
            rows_eff = RLIM_W'(MAX_ROWS);
        end else begin
            rows_eff = RLIM_W'(rows_cfg);
        end
        if (CLIM_W'(cols_cfg) < CLIM_W'(hsfp_pkg::MIN_SIZE)) begin
            cols_eff = CLIM_W'(hsfp_pkg::MIN_SIZE);
        end else if (CLIM_W'(cols_cfg) > CLIM_W'(MAX_COLS)) begin
            cols_eff = CLIM_W'(MAX_COLS);
        end else begin
            cols_eff = CLIM_W'(cols_cfg);
        end
    end

    always_comb begin
        row_last = rows_eff - RLIM_W'(1);
        col_last = cols_eff - CLIM_W'(1);
        row_ext  = RLIM_W'(row_cnt_reg);
        col_ext  = CLIM_W'(col_cnt_reg);
        last_row = row_ext >= row_last;
        last_col = col_ext >= col_last;

        row32    = 32'(row_cnt_reg);
        row_up32 = row32 - 32'd1;
        col32    = 32'(col_cnt_reg);

        tag_next.emit_up   = row_cnt_reg != '0;
        tag_next.emit_own  = last_row;
        tag_next.interior  = (row_cnt_reg >= ROW_W'(2)) && (row_ext < rows_eff)
                             && (col_cnt_reg != '0) && (col_ext < col_last);
        tag_next.frame_end = last_col;
        tag_next.up_row    = row_up32[hsfp_pkg::IDX_W-1:0];
        tag_next.own_row   = row32[hsfp_pkg::IDX_W-1:0];
        tag_next.col       = col32[hsfp_pkg::IDX_W-1:0];

        // a counter at or past the last index wraps
        if (last_col) begin
            col_cnt_next = '0;
            row_cnt_next = last_row ? '0 : row_cnt_reg + ROW_W'(1);
        end else begin
            col_cnt_next = col_cnt_reg + COL_W'(1);
            row_cnt_next = row_cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
        end else if (accept) begin
            row_cnt_reg <= row_cnt_next;
            col_cnt_reg <= col_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            tag_reg <= tag_next;
        end
    end

    assign col      = col_cnt_reg;
    assign col_plus = col_cnt_reg + COL_W'(1);

endmodule

[rtl/hsfp_line_buf.sv]
`timescale 1ns / 1ps
// two row stores with registered reads and the neighbour registers
module hsfp_line_buf #(
    parameter int MAX_COLS = hsfp_pkg::MAX_COLS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                rd_en,
    input  logic [$clog2(MAX_COLS)-1:0]         col,
    input  logic [$clog2(MAX_COLS)-1:0]         col_plus,
    input  logic [hsfp_pkg::VALUE_W-1:0]        wr_value,
    output logic [hsfp_pkg::VALUE_W-1:0]        center,
    output logic [hsfp_pkg::VALUE_W-1:0]        right,
    output logic [hsfp_pkg::VALUE_W-1:0]        up,
    output logic [hsfp_pkg::VALUE_W-1:0]        left,
    output logic [hsfp_pkg::VALUE_W-1:0]        down
);

    localparam int COL_W = $clog2(MAX_COLS);

    logic [hsfp_pkg::VALUE_W-1:0] above_mem [MAX_COLS];
    logic [hsfp_pkg::VALUE_W-1:0] two_mem   [MAX_COLS];

    logic [hsfp_pkg::VALUE_W-1:0] center_reg, right_reg, up_reg, left_reg, down_reg;
    logic                         wr_pend_reg;
    logic [COL_W-1:0]             wr_addr_reg;

    // read-first: the row above is read and overwritten in the same cycle
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            center_reg      <= above_mem[col];
            right_reg       <= above_mem[col_plus];
            up_reg          <= two_mem[col];
            left_reg        <= center_reg;
            down_reg        <= wr_value;
            above_mem[col]  <= wr_value;
            wr_addr_reg     <= col;
        end
        // old row-above value moves down in the cycle after it is read
        if (wr_pend_reg) begin
            two_mem[wr_addr_reg] <= center_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_pend_reg <= 1'b0;
        end else begin
            wr_pend_reg <= rd_en;
        end
    end

    assign center = center_reg;
    assign right  = right_reg;
    assign up     = up_reg;
    assign left   = left_reg;
    assign down   = down_reg;

endmodule

[rtl/hsfp_stencil_pipe.sv]
`timescale 1ns / 1ps
// laplacian, alpha product, rounding and saturating update
module hsfp_stencil_pipe (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  logic                           in_valid,
    input  hsfp_pkg::tag_t                 in_tag,
    input  logic [hsfp_pkg::ALPHA_W-1:0]   alpha,
    input  logic [hsfp_pkg::VALUE_W-1:0]   left,
    input  logic [hsfp_pkg::VALUE_W-1:0]   right,
    input  logic [hsfp_pkg::VALUE_W-1:0]   up,
    input  logic [hsfp_pkg::VALUE_W-1:0]   center,
    input  logic [hsfp_pkg::VALUE_W-1:0]   down,
    output logic                           out_valid,
    output hsfp_pkg::tag_t                 out_tag,
    output logic [hsfp_pkg::VALUE_W-1:0]   out_up_value,
    output logic [hsfp_pkg::VALUE_W-1:0]   out_own_value
);

    localparam int D_W   = hsfp_pkg::D_W;
    localparam int P_W   = hsfp_pkg::P_W;
    localparam int Q_W   = hsfp_pkg::Q_W;
    localparam int SUM_W = hsfp_pkg::SUM_W;
    localparam int V_W   = hsfp_pkg::VALUE_W;
    localparam logic signed [P_W-1:0] BIAS = P_W'(hsfp_pkg::ROUND_BIAS);

    logic                   s2_valid_reg, s3_valid_reg, s4_valid_reg;
    hsfp_pkg::tag_t         s2_tag_reg, s3_tag_reg, s4_tag_reg;
    logic [V_W-1:0]         s2_center_reg, s3_center_reg, s4_center_reg;
    logic [V_W-1:0]         s2_down_reg, s3_down_reg, s4_down_reg;
    logic signed [D_W-1:0]  d_next, s2_d_reg;
    logic signed [P_W-1:0]  p_next, s3_p_reg, p_bias;
    logic signed [Q_W-1:0]  q_next, s4_q_reg;
    logic signed [15:0]     alpha_s;
    logic signed [SUM_W-1:0] sum;
    logic [V_W-1:0]         sat;

    assign alpha_s = {1'b0, alpha};

    always_comb begin
        d_next = D_W'($signed(left)) + D_W'($signed(right)) + D_W'($signed(up))
               + D_W'($signed(down)) - (D_W'($signed(center)) <<< 2);
        p_next = s2_d_reg * alpha_s;
        // round to nearest, ties upward
        p_bias = s3_p_reg + BIAS;
        q_next = Q_W'(p_bias >>> hsfp_pkg::FRAC_SHIFT);
        sum    = SUM_W'($signed(s4_center_reg)) + SUM_W'(s4_q_reg);
        if (sum[SUM_W-1:V_W-1] == '0 || sum[SUM_W-1:V_W-1] == '1) begin
            sat = sum[V_W-1:0];
        end else if (sum[SUM_W-1]) begin
            sat = hsfp_pkg::VALUE_MIN;
        end else begin
            sat = hsfp_pkg::VALUE_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= in_valid;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_tag_reg    <= in_tag;
            s2_center_reg <= center;
            s2_down_reg   <= down;
            s2_d_reg      <= d_next;
            s3_tag_reg    <= s2_tag_reg;
            s3_center_reg <= s2_center_reg;
            s3_down_reg   <= s2_down_reg;
            s3_p_reg      <= p_next;
            s4_tag_reg    <= s3_tag_reg;
            s4_center_reg <= s3_center_reg;
            s4_down_reg   <= s3_down_reg;
            s4_q_reg      <= q_next;
        end
    end

    assign out_valid     = s4_valid_reg;
    assign out_tag       = s4_tag_reg;
    assign out_up_value  = s4_tag_reg.interior ? sat : s4_center_reg;
    assign out_own_value = s4_down_reg;

endmodule

[rtl/hsfp_out_stage.sv]
`timescale 1ns / 1ps
// result register holding up to two pending words per input word
module hsfp_out_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    input  hsfp_pkg::tag_t                 in_tag,
    input  logic [hsfp_pkg::VALUE_W-1:0]   up_value,
    input  logic [hsfp_pkg::VALUE_W-1:0]   own_value,
    output logic                           load,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [hsfp_pkg::VALUE_W-1:0]   m_next_value,
    output logic [hsfp_pkg::IDX_W-1:0]     m_out_row,
    output logic [hsfp_pkg::IDX_W-1:0]     m_out_col,
    output logic                           m_frame_end
);

    logic                         pend_up_reg, pend_own_reg;
    logic [hsfp_pkg::VALUE_W-1:0] up_value_reg, own_value_reg;
    logic [hsfp_pkg::IDX_W-1:0]   up_row_reg, own_row_reg, col_reg;
    logic                         frame_end_reg;

    // free next cycle if empty or the last pending word leaves now
    assign load = !(pend_up_reg || pend_own_reg)
                  || (m_ready && (pend_up_reg ^ pend_own_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_up_reg  <= 1'b0;
            pend_own_reg <= 1'b0;
        end else if (load) begin
            pend_up_reg  <= in_valid && in_tag.emit_up;
            pend_own_reg <= in_valid && in_tag.emit_own;
        end else if (m_ready && pend_up_reg) begin
            pend_up_reg  <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            up_value_reg  <= up_value;
            own_value_reg <= own_value;
            up_row_reg    <= in_tag.up_row;
            own_row_reg   <= in_tag.own_row;
            col_reg       <= in_tag.col;
            frame_end_reg <= in_tag.frame_end;
        end
    end

    // finished cell above goes out before the copied last-row cell
    assign m_valid      = pend_up_reg || pend_own_reg;
    assign m_next_value = pend_up_reg ? up_value_reg : own_value_reg;
    assign m_out_row    = pend_up_reg ? up_row_reg : own_row_reg;
    assign m_out_col    = col_reg;
    assign m_frame_end  = !pend_up_reg && frame_end_reg;

endmodule

[rtl/heat_stencil_five_point.sv]
`timescale 1ns / 1ps
// top level of the five-point explicit heat-equation stencil
//
// usage
// - grid cells enter on the s_ channel in raster order, one word per cell,
//   signed q23.8; each interior cell of the previous row leaves on the m_
//   channel as c + alpha*(l + r + u + d - 4c), border cells are copied
// - results lag the input by one row; a word of the last row also gives out
//   its own copied value right after the finished cell above it
// - alpha, rows and columns are set through the cfg_ write port while idle
// - an accepted word passes the neighbour and tag registers, the laplacian,
//   product and rounding registers and the result register, then m_valid rises
// - throughput: one word per cycle while results are taken; a last-row word
//   has two results for the single port; the next enters as the second leaves
// - receiver stall on a waiting result: pipe holds, s_ready drops that cycle
// - reset: position counters clear, alpha clears, size registers go to
//   1024 by 1024; the row stores keep their contents and need no clearing
module heat_stencil_five_point #(
    parameter int MAX_ROWS = hsfp_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = hsfp_pkg::MAX_COLS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [hsfp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hsfp_pkg::CFG_DATA_W-1:0]      cfg_data,
    // cell input
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [hsfp_pkg::VALUE_W-1:0]  s_cell_value,
    // result output
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [hsfp_pkg::VALUE_W-1:0]  m_next_value,
    output logic [hsfp_pkg::IDX_W-1:0]           m_out_row,
    output logic [hsfp_pkg::IDX_W-1:0]           m_out_col,
    output logic                                 m_frame_end
);

    localparam int COL_W = $clog2(MAX_COLS);

    // configuration registers
    logic [hsfp_pkg::ALPHA_W-1:0]  alpha_reg;
    logic [hsfp_pkg::SIZE_W-1:0]   rows_reg, cols_reg;

    // pipe control
    logic                          advance, accept;
    logic                          s1_valid_reg;
    hsfp_pkg::tag_t                s1_tag, pipe_tag;
    logic [COL_W-1:0]              col, col_plus;

    // neighbourhood of the cell one row above the incoming word
    logic [hsfp_pkg::VALUE_W-1:0]  nb_center, nb_right, nb_up, nb_left, nb_down;
    logic                          pipe_valid;
    logic [hsfp_pkg::VALUE_W-1:0]  up_value, own_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg <= '0;
            rows_reg  <= hsfp_pkg::ROWS_RESET;
            cols_reg  <= hsfp_pkg::COLS_RESET;
        end else if (cfg_wr_en) begin
            unique case (hsfp_pkg::cfg_idx_t'(cfg_index))
                hsfp_pkg::CFG_ALPHA: alpha_reg <= cfg_data[hsfp_pkg::ALPHA_W-1:0];
                hsfp_pkg::CFG_ROWS:  rows_reg  <= cfg_data[hsfp_pkg::SIZE_W-1:0];
                hsfp_pkg::CFG_COLS:  cols_reg  <= cfg_data[hsfp_pkg::SIZE_W-1:0];
                default: begin
                    // unused index, write ignored
                end
            endcase
        end
    end

    // all stages move together whenever the result register can take a word
    assign s_ready = advance;
    assign accept  = s_valid && advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= s_valid;
        end
    end

    hsfp_raster_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_raster (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .rows_cfg (rows_reg),
        .cols_cfg (cols_reg),
        .col      (col),
        .col_plus (col_plus),
        .tag_reg  (s1_tag)
    );

    hsfp_line_buf #(
        .MAX_COLS (MAX_COLS)
    ) u_line_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept),
        .col      (col),
        .col_plus (col_plus),
        .wr_value (s_cell_value),
        .center   (nb_center),
        .right    (nb_right),
        .up       (nb_up),
        .left     (nb_left),
        .down     (nb_down)
    );

    hsfp_stencil_pipe u_pipe (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (advance),
        .in_valid      (s1_valid_reg),
        .in_tag        (s1_tag),
        .alpha         (alpha_reg),
        .left          (nb_left),
        .right         (nb_right),
        .up            (nb_up),
        .center        (nb_center),
        .down          (nb_down),
        .out_valid     (pipe_valid),
        .out_tag       (pipe_tag),
        .out_up_value  (up_value),
        .out_own_value (own_value)
    );

    hsfp_out_stage u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (pipe_valid),
        .in_tag       (pipe_tag),
        .up_value     (up_value),
        .own_value    (own_value),
        .load         (advance),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_next_value (m_next_value),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_frame_end  (m_frame_end)
    );

endmodule

[sim/heat_stencil_five_point_test.sv]
`timescale 1ns / 1ps
// self-checking testbench for the five-point heat stencil with a built-in grid predictor
module heat_stencil_five_point_test;

    localparam int     CLK_HALF      = 10;
    localparam int     RESET_CYCLES  = 7;
    localparam int     SETTLE_CYCLES = 16;       // longer than the pipe takes to drain
    localparam int     RANDOM_CELLS  = 1000;
    localparam int     IDLE_PERCENT  = 16;
    localparam int     CALM_PERIOD   = 5000;     // first part of each period has no idling
    localparam int     CALM_CYCLES   = 800;
    localparam int     SQUEEZE_AT    = 400;      // lands in the random frames
    localparam int     SQUEEZE_LEN   = 400;
    localparam int     SQUEEZE_BACKLOG = 16;     // words still queued when the hold starts
    localparam int     MAX_REPORTS   = 10;
    localparam longint TIMEOUT_NS    = 8_000_000;

    typedef struct packed {
        logic [hsfp_pkg::VALUE_W-1:0] value;
        logic [hsfp_pkg::IDX_W-1:0]   row;
        logic [hsfp_pkg::IDX_W-1:0]   col;
        logic                         last;
    } grid_result_t;

    // small grid with rounding ties on both interior cells under alpha of one lsb
    localparam logic [hsfp_pkg::VALUE_W-1:0] TIE_GRID [12] = '{
        32'sd0, 32'sd16384, -32'sd32768, 32'sd0,
        32'sd0, 32'sd0,     32'sd0,      32'sd0,
        32'sd0, 32'sd16384, 32'sd0,      32'sd0
    };

    logic                                aclk         = 1'b0;
    logic                                aresetn      = 1'b0;
    logic                                cfg_wr_en    = 1'b0;
    logic [hsfp_pkg::CFG_IDX_W-1:0]      cfg_index    = hsfp_pkg::CFG_ALPHA;
    logic [hsfp_pkg::CFG_DATA_W-1:0]     cfg_data     = '0;
    logic                                s_valid      = 1'b0;
    logic                                s_ready;
    logic signed [hsfp_pkg::VALUE_W-1:0] s_cell_value = '0;
    logic                                m_valid;
    logic                                m_ready      = 1'b0;
    logic signed [hsfp_pkg::VALUE_W-1:0] m_next_value;
    logic [hsfp_pkg::IDX_W-1:0]          m_out_row;
    logic [hsfp_pkg::IDX_W-1:0]          m_out_col;
    logic                                m_frame_end;

    heat_stencil_five_point u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cell_value (s_cell_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_next_value (m_next_value),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_frame_end  (m_frame_end)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // ------------------------------------------------------------------
    // predictor: shadow registers, two line stores and the raster position
    // ------------------------------------------------------------------
    logic [hsfp_pkg::ALPHA_W-1:0] alpha_reg = '0;
    logic [hsfp_pkg::SIZE_W-1:0]  rows_reg  = hsfp_pkg::ROWS_RESET;
    logic [hsfp_pkg::SIZE_W-1:0]  cols_reg  = hsfp_pkg::COLS_RESET;
    logic [hsfp_pkg::VALUE_W-1:0] line_above     [hsfp_pkg::MAX_COLS_DEF];
    logic [hsfp_pkg::VALUE_W-1:0] line_two_above [hsfp_pkg::MAX_COLS_DEF];
    logic [hsfp_pkg::VALUE_W-1:0] left_prev = '0;
    int unsigned                  row_pos   = 0;
    int unsigned                  col_pos   = 0;

    grid_result_t                 results_due[$];
    logic [hsfp_pkg::VALUE_W-1:0] cells_to_send[$];

    int  cells_taken  = 0;
    int  fault_count  = 0;
    int  send_tick    = 0;
    int  recv_tick    = 0;
    int  hold_left    = 0;
    bit  squeeze_done = 1'b0;
    bit  rest_now;
    grid_result_t want;

    // sizes outside the legal range are pulled to the nearest limit
    function automatic int unsigned grid_limit(input logic [hsfp_pkg::SIZE_W-1:0] v,
                                               input int unsigned top);
        if (v < hsfp_pkg::MIN_SIZE) return hsfp_pkg::MIN_SIZE;
        if (v > top) return top;
        return 32'(v);
    endfunction

    // one explicit step of an interior cell: round half up, then saturate
    function automatic logic [hsfp_pkg::VALUE_W-1:0] diffuse(
            input logic signed [hsfp_pkg::VALUE_W-1:0] ctr, lf, rt, up, dn);
        longint lap;
        longint scaled;
        longint total;
        lap    = longint'(lf) + longint'(rt) + longint'(up) + longint'(dn)
                 - 4 * longint'(ctr);
        scaled = (lap * longint'(alpha_reg) + hsfp_pkg::ROUND_BIAS) >>> hsfp_pkg::FRAC_SHIFT;
        total  = longint'(ctr) + scaled;
        if (total > longint'(signed'(hsfp_pkg::VALUE_MAX))) return hsfp_pkg::VALUE_MAX;
        if (total < longint'(signed'(hsfp_pkg::VALUE_MIN))) return hsfp_pkg::VALUE_MIN;
        return total[hsfp_pkg::VALUE_W-1:0];
    endfunction

    // one accepted word: finish the cell above it, shift the stores, copy out in the last row
    function automatic void advance_stencil(input logic [hsfp_pkg::VALUE_W-1:0] word_in);
        int unsigned                  rows_eff;
        int unsigned                  cols_eff;
        int unsigned                  r;
        int unsigned                  c;
        bit                           last_row;
        bit                           last_col;
        logic [hsfp_pkg::VALUE_W-1:0] v;
        rows_eff = grid_limit(rows_reg, hsfp_pkg::MAX_ROWS_DEF);
        cols_eff = grid_limit(cols_reg, hsfp_pkg::MAX_COLS_DEF);
        r        = row_pos;
        c        = col_pos;
        last_row = r >= rows_eff - 1;
        last_col = c >= cols_eff - 1;
        if (r >= 1) begin
            v = line_above[c];
            if (r >= 2 && r - 1 < rows_eff - 1 && c >= 1 && c < cols_eff - 1) begin
                v = diffuse(line_above[c], left_prev, line_above[c + 1],
                            line_two_above[c], word_in);
            end
            results_due.push_back('{v, hsfp_pkg::IDX_W'(r - 1), hsfp_pkg::IDX_W'(c), 1'b0});
        end
        left_prev         = line_above[c];
        line_two_above[c] = line_above[c];
        line_above[c]     = word_in;
        if (last_row) begin
            results_due.push_back('{word_in, hsfp_pkg::IDX_W'(r), hsfp_pkg::IDX_W'(c),
                                    last_col});
        end
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    // words still needed to close the frame from the current position
    function automatic int unsigned frame_left();
        int unsigned rows_eff;
        int unsigned cols_eff;
        int unsigned in_row;
        int unsigned rows_after;
        rows_eff   = grid_limit(rows_reg, hsfp_pkg::MAX_ROWS_DEF);
        cols_eff   = grid_limit(cols_reg, hsfp_pkg::MAX_COLS_DEF);
        in_row     = (col_pos >= cols_eff - 1) ? 1 : cols_eff - col_pos;
        rows_after = (row_pos >= rows_eff - 1) ? 0 : rows_eff - 1 - row_pos;
        return in_row + rows_after * cols_eff;
    endfunction

    // ------------------------------------------------------------------
    // random content
    // ------------------------------------------------------------------
    function automatic logic [hsfp_pkg::VALUE_W-1:0] pick_cell();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 3))
                    0:       return hsfp_pkg::VALUE_MAX;
                    1:       return hsfp_pkg::VALUE_MIN;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            1:       return $urandom_range(0, 8191) - 32'd4096;
            default: return $urandom();
        endcase
    endfunction

    // mostly stable alphas, now and then one above a quarter
    function automatic logic [hsfp_pkg::CFG_DATA_W-1:0] pick_alpha();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 15'd16384;
            2:       return 15'($urandom_range(16385, 32767));
            default: return 15'($urandom_range(0, 16384));
        endcase
    endfunction

    // small grids, sometimes below the minimum, sometimes junk in the unused top bits
    function automatic logic [hsfp_pkg::CFG_DATA_W-1:0] pick_size(input int unsigned top);
        logic [hsfp_pkg::CFG_DATA_W-1:0] w;
        if ($urandom_range(0, 9) == 0) w = 15'($urandom_range(0, hsfp_pkg::MIN_SIZE - 1));
        else w = 15'($urandom_range(hsfp_pkg::MIN_SIZE, top));
        if ($urandom_range(0, 7) == 0) begin
            w[hsfp_pkg::CFG_DATA_W-1:hsfp_pkg::SIZE_W] = 4'($urandom());
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // fault logging: first few in full, the rest only counted
    // ------------------------------------------------------------------
    function automatic void log_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS) $display("[%0t] %s", $time, msg);
    endfunction

    // ------------------------------------------------------------------
    // input driver: offers queued words, idles at random outside calm stretches
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        send_tick++;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                advance_stencil(s_cell_value);
                cells_taken++;
            end
            if (!s_valid || s_ready) begin
                rest_now = (send_tick % CALM_PERIOD >= CALM_CYCLES)
                           && ($urandom_range(0, 99) < IDLE_PERCENT);
                if (cells_to_send.size() != 0 && !rest_now) begin
                    s_valid      <= 1'b1;
                    s_cell_value <= cells_to_send.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result receiver: random stalls plus one long hold so the pipe backs up
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        recv_tick++;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!squeeze_done && cells_taken >= SQUEEZE_AT
                     && cells_to_send.size() > SQUEEZE_BACKLOG) begin
            squeeze_done = 1'b1;
            hold_left    = SQUEEZE_LEN;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !((recv_tick % CALM_PERIOD >= CALM_CYCLES)
                         && ($urandom_range(0, 99) < IDLE_PERCENT));
        end
    end

    // ------------------------------------------------------------------
    // result monitor: every accepted word against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                log_fault($sformatf("unexpected word: value %h row %0d col %0d end %b",
                                    m_next_value, m_out_row, m_out_col, m_frame_end));
            end else begin
                want = results_due.pop_front();
                if (m_next_value !== want.value || m_out_row !== want.row
                        || m_out_col !== want.col || m_frame_end !== want.last) begin
                    log_fault($sformatf({"mismatch: expected value %h row %0d col %0d end %b,",
                                         " got value %h row %0d col %0d end %b"},
                                        want.value, want.row, want.col, want.last,
                                        m_next_value, m_out_row, m_out_col, m_frame_end));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // configuration helpers, only used while the block is idle
    // ------------------------------------------------------------------
    task automatic set_reg(input hsfp_pkg::cfg_idx_t idx,
                           input logic [hsfp_pkg::CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            hsfp_pkg::CFG_ALPHA: alpha_reg = data[hsfp_pkg::ALPHA_W-1:0];
            hsfp_pkg::CFG_ROWS:  rows_reg  = data[hsfp_pkg::SIZE_W-1:0];
            hsfp_pkg::CFG_COLS:  cols_reg  = data[hsfp_pkg::SIZE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic close_cfg();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // all words taken and all results back, then let the pipe drain words
    // that give nothing (first row of a frame)
    task automatic wait_idle();
        @(negedge aclk);
        while (cells_to_send.size() != 0 || s_valid || results_due.size() != 0) begin
            @(negedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_random(input int unsigned n);
        repeat (n) cells_to_send.push_back(pick_cell());
    endtask

    // ------------------------------------------------------------------
    // stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned                     n;
        int unsigned                     random_cells;
        bit                              wrote;
        logic [hsfp_pkg::CFG_DATA_W-1:0] size_word;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // unstable alpha on a checkerboard of the extremes, sizes below the minimum
        set_reg(hsfp_pkg::CFG_ALPHA, 15'd32767);
        set_reg(hsfp_pkg::CFG_ROWS, 15'd0);
        set_reg(hsfp_pkg::CFG_COLS, 15'd2);
        close_cfg();
        for (int r = 0; r < hsfp_pkg::MIN_SIZE; r++) begin
            for (int c = 0; c < hsfp_pkg::MIN_SIZE; c++) begin
                cells_to_send.push_back(((r + c) % 2 == 0) ? hsfp_pkg::VALUE_MAX
                                                           : hsfp_pkg::VALUE_MIN);
            end
        end
        wait_idle();

        // rounding ties, upward and toward plus infinity on the negative side
        set_reg(hsfp_pkg::CFG_ALPHA, 15'd1);
        set_reg(hsfp_pkg::CFG_ROWS, 15'd3);
        set_reg(hsfp_pkg::CFG_COLS, 15'd4);
        close_cfg();
        foreach (TIE_GRID[i]) cells_to_send.push_back(TIE_GRID[i]);
        wait_idle();

        // height above the limit, then cut short mid-frame: the row counter is past the end
        set_reg(hsfp_pkg::CFG_ALPHA, pick_alpha());
        set_reg(hsfp_pkg::CFG_ROWS, 15'd2047);
        close_cfg();
        queue_random(30);
        wait_idle();
        set_reg(hsfp_pkg::CFG_ROWS, 15'd3);
        close_cfg();
        queue_random(frame_left());
        wait_idle();

        // width cut mid-row past the current column, so the column counter wraps there
        set_reg(hsfp_pkg::CFG_ROWS, 15'd5);
        set_reg(hsfp_pkg::CFG_COLS, 15'd12);
        close_cfg();
        queue_random(31);
        wait_idle();
        set_reg(hsfp_pkg::CFG_COLS, 15'd4);
        close_cfg();
        queue_random(frame_left());
        wait_idle();

        // random small frames, some stopped part way and resized
        random_cells = 0;
        while (random_cells < RANDOM_CELLS) begin
            wrote = 1'b0;
            if ($urandom_range(0, 1)) begin
                set_reg(hsfp_pkg::CFG_ALPHA, pick_alpha());
                wrote = 1'b1;
            end
            if ($urandom_range(0, 1)) begin
                set_reg(hsfp_pkg::CFG_ROWS, pick_size(8));
                wrote = 1'b1;
            end
            if ($urandom_range(0, 1)) begin
                size_word = pick_size(12);
                // past the first row, widening would read store entries never filled
                if (row_pos != 0
                        && grid_limit(size_word[hsfp_pkg::SIZE_W-1:0], hsfp_pkg::MAX_COLS_DEF)
                        > grid_limit(cols_reg, hsfp_pkg::MAX_COLS_DEF)) begin
                    size_word = 15'(cols_reg);
                end
                set_reg(hsfp_pkg::CFG_COLS, size_word);
                wrote = 1'b1;
            end
            if (wrote) close_cfg();
            n = frame_left();
            if (n > 1 && $urandom_range(0, 4) == 0) n = $urandom_range(1, n - 1);
            queue_random(n);
            random_cells += n;
            wait_idle();
        end

        if (fault_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule
